>>> hdl/rkdt_pkg.sv
package rkdt_pkg;

  // default storage widths
  localparam int TIME_WIDTH_DEF     = 32;
  localparam int POSITION_WIDTH_DEF = 16;

  // fixed field widths
  localparam int NOW_W      = 32;
  localparam int POS_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd50;
  localparam logic [CFG_W-1:0] CLICK_SEP_RESET = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 1'b0,
    REG_CLICK_SEP = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ROTATE = 2'd0,
    OP_PRESS  = 2'd1,
    OP_ACK    = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     opcode;
    logic [NOW_W-1:0]        now_ms;
    logic                    clk_level;
    logic                    dt_level;
    logic signed [POS_W-1:0] new_position;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    updated;
    logic                    clicked;
    logic                    accepted;
  } out_item_t;

  // settings seen by the event core
  typedef struct packed {
    logic [CFG_W-1:0] debounce_delay;
    logic [CFG_W-1:0] min_click_separation;
  } cfg_t;

endpackage

>>> hdl/rkdt_in_stage.sv
module rkdt_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rkdt_pkg::in_item_t in_data,
  output logic              s1_valid,
  output rkdt_pkg::in_item_t s1_data,
  input  logic              s1_ready
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  rkdt_pkg::in_item_t s1_data_r;
  logic               load;

  assign in_ready = !s1_valid_r || s1_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

>>> hdl/rkdt_core.sv
module rkdt_core #(
  parameter int TIME_WIDTH     = rkdt_pkg::TIME_WIDTH_DEF,
  parameter int POSITION_WIDTH = rkdt_pkg::POSITION_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rkdt_pkg::cfg_t     cfg,
  input  logic               s1_valid,
  input  rkdt_pkg::in_item_t s1_data,
  output logic               s1_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rkdt_pkg::out_item_t out_data
);

  logic [POSITION_WIDTH-1:0] knob_r, knob_nxt;
  logic [TIME_WIDTH-1:0]     last_event_r, last_event_nxt;
  logic [TIME_WIDTH-1:0]     last_click_r, last_click_nxt;
  logic                      upd_r, upd_nxt;
  logic                      clk_pend_r, clk_pend_nxt;
  logic                      acc;
  logic                      out_valid_r;
  rkdt_pkg::out_item_t       out_data_r;
  logic                      adv;

  logic [TIME_WIDTH-1:0]     now_t;
  logic [TIME_WIDTH-1:0]     event_limit;
  logic [TIME_WIDTH-1:0]     click_limit;
  logic                      debounce_ok;
  logic                      click_ok;

  assign s1_ready = !out_valid_r || out_ready;
  assign adv      = s1_valid && s1_ready;

  // wrapping limits, unsigned compare
  assign now_t       = TIME_WIDTH'(s1_data.now_ms);
  assign event_limit = last_event_r + TIME_WIDTH'(cfg.debounce_delay);
  assign click_limit = last_click_r + TIME_WIDTH'(cfg.min_click_separation);
  assign debounce_ok = now_t > event_limit;
  assign click_ok    = now_t > click_limit;

  always_comb begin
    knob_nxt       = knob_r;
    last_event_nxt = last_event_r;
    last_click_nxt = last_click_r;
    upd_nxt        = upd_r;
    clk_pend_nxt   = clk_pend_r;
    acc            = 1'b0;
    case (s1_data.opcode)
      rkdt_pkg::OP_ROTATE: begin
        if (debounce_ok) begin
          acc            = 1'b1;
          last_event_nxt = now_t;
          upd_nxt        = 1'b1;
          if (s1_data.clk_level == s1_data.dt_level) begin
            knob_nxt = knob_r + POSITION_WIDTH'(1);
          end else begin
            knob_nxt = knob_r - POSITION_WIDTH'(1);
          end
        end
      end
      rkdt_pkg::OP_PRESS: begin
        if (debounce_ok) begin
          acc            = 1'b1;
          last_event_nxt = now_t;
          if (click_ok) begin
            clk_pend_nxt   = 1'b1;
            upd_nxt        = 1'b1;
            last_click_nxt = now_t;
          end
        end
      end
      rkdt_pkg::OP_ACK: begin
        upd_nxt      = 1'b0;
        clk_pend_nxt = 1'b0;
      end
      rkdt_pkg::OP_LOAD: begin
        // signed cast sign-extends or truncates
        knob_nxt = POSITION_WIDTH'(s1_data.new_position);
        upd_nxt  = 1'b1;
      end
      default: begin
        knob_nxt = knob_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_r       <= '0;
      last_event_r <= '0;
      last_click_r <= '0;
      upd_r        <= 1'b1;
      clk_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        knob_r       <= knob_nxt;
        last_event_r <= last_event_nxt;
        last_click_r <= last_click_nxt;
        upd_r        <= upd_nxt;
        clk_pend_r   <= clk_pend_nxt;
      end
      if (s1_ready) begin
        out_valid_r <= s1_valid;
      end
    end
  end

  // result register, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.position <= rkdt_pkg::POS_W'(knob_nxt);
      out_data_r.updated  <= upd_nxt;
      out_data_r.clicked  <= clk_pend_nxt;
      out_data_r.accepted <= acc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/rotary_knob_debounce_tracker.sv
// rotary knob tracker with shared debounce and click separation
//
// input channel (in_valid / in_ready / in_data): one event per transaction,
//   rotate, press, acknowledge or load position, with a millisecond stamp
// result channel (out_valid / out_ready / out_data): exactly one result per
//   event, carrying the position and flags after that event
// config port (cfg_we / cfg_index / cfg_wdata): debounce delay and minimum
//   click separation, written only while the block is idle; the user must keep to this, the block does not enforce it
//
// path: an input transaction goes through the input register, then through one
//   add-compare against the stored times into the result register
// throughput: 1 event per cycle while out_ready stays high, set by the registered state update
// reset: position 0, both stored times 0, updated flag set, clicked clear,
//   delays back to 50 ms and 1000 ms, both channels empty
// stall: while out_ready is low the result register holds, the input
//   register fills behind it, and in_ready drops only when both are full
module rotary_knob_debounce_tracker #(
  parameter int TIME_WIDTH     = rkdt_pkg::TIME_WIDTH_DEF,
  parameter int POSITION_WIDTH = rkdt_pkg::POSITION_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rkdt_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rkdt_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [rkdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rkdt_pkg::CFG_W-1:0]        cfg_wdata
);

  // configuration registers
  logic [rkdt_pkg::CFG_W-1:0] debounce_delay_r;
  logic [rkdt_pkg::CFG_W-1:0] click_sep_r;
  rkdt_pkg::cfg_t             cfg;

  // input stage to core
  logic               s1_valid;
  logic               s1_ready;
  rkdt_pkg::in_item_t s1_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_delay_r <= rkdt_pkg::DEBOUNCE_RESET;
      click_sep_r      <= rkdt_pkg::CLICK_SEP_RESET;
    end else if (cfg_we) begin
      case (rkdt_pkg::reg_idx_t'(cfg_index))
        rkdt_pkg::REG_DEBOUNCE:  debounce_delay_r <= cfg_wdata;
        rkdt_pkg::REG_CLICK_SEP: click_sep_r      <= cfg_wdata;
        default: begin
          // unknown index, ignored
          debounce_delay_r <= debounce_delay_r;
        end
      endcase
    end
  end

  assign cfg.debounce_delay       = debounce_delay_r;
  assign cfg.min_click_separation = click_sep_r;

  // input register
  rkdt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  // debounce, position and flag state with the result register
  rkdt_core #(
    .TIME_WIDTH     (TIME_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // a click is never reported without the updated flag
  a_click_implies_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clicked |-> out_data.updated)
    else $error("clicked reported without updated");

  // acknowledge clears both flags and never reports acceptance
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_ready && (s1_data.opcode == rkdt_pkg::OP_ACK)
    |=> out_valid && !out_data.updated && !out_data.clicked && !out_data.accepted)
    else $error("acknowledge result carries a flag");

  // load position always raises the updated flag
  a_load_sets_upd: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_ready && (s1_data.opcode == rkdt_pkg::OP_LOAD)
    |=> out_valid && out_data.updated && !out_data.accepted)
    else $error("load result without updated");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

// keeps its own copy of the knob state and the two delays, works out the
// result of every accepted event and checks the results in order
class knob_scoreboard;
  logic [rkdt_pkg::CFG_W-1:0]        debounce_ms;
  logic [rkdt_pkg::CFG_W-1:0]        click_gap_ms;
  logic signed [rkdt_pkg::POS_W-1:0] knob_pos;
  logic [rkdt_pkg::NOW_W-1:0]        last_evt;
  logic [rkdt_pkg::NOW_W-1:0]        last_click;
  bit                                upd_flag;
  bit                                click_flag;
  rkdt_pkg::out_item_t               expected_results[$];
  int unsigned                       n_errors;
  int unsigned                       n_events;
  int unsigned                       n_checked;
  int unsigned                       n_steps;
  int unsigned                       n_clicks;
  int unsigned                       n_rejected;

  function new();
    debounce_ms  = rkdt_pkg::DEBOUNCE_RESET;
    click_gap_ms = rkdt_pkg::CLICK_SEP_RESET;
    knob_pos     = '0;
    last_evt     = '0;
    last_click   = '0;
    upd_flag     = 1'b1;
    click_flag   = 1'b0;
    n_errors     = 0;
    n_events     = 0;
    n_checked    = 0;
    n_steps      = 0;
    n_clicks     = 0;
    n_rejected   = 0;
  endfunction

  function void set_reg(rkdt_pkg::reg_idx_t idx, logic [rkdt_pkg::CFG_W-1:0] value);
    case (idx)
      rkdt_pkg::REG_DEBOUNCE:  debounce_ms  = value;
      rkdt_pkg::REG_CLICK_SEP: click_gap_ms = value;
      default: ;
    endcase
  endfunction

  // shared quiet time, sum wraps at the stamp width
  function bit debounce_ok(logic [rkdt_pkg::NOW_W-1:0] now);
    logic [rkdt_pkg::NOW_W-1:0] limit;
    limit = last_evt + debounce_ms;
    if (now > limit) begin
      last_evt = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_event(rkdt_pkg::in_item_t ev);
    rkdt_pkg::out_item_t        res;
    logic [rkdt_pkg::NOW_W-1:0] click_limit;
    res.accepted = 1'b0;
    case (ev.opcode)
      rkdt_pkg::OP_ROTATE: begin
        if (debounce_ok(ev.now_ms)) begin
          res.accepted = 1'b1;
          if (ev.clk_level == ev.dt_level) knob_pos = knob_pos + 16'sd1;
          else knob_pos = knob_pos - 16'sd1;
          upd_flag = 1'b1;
          n_steps++;
        end else begin
          n_rejected++;
        end
      end
      rkdt_pkg::OP_PRESS: begin
        if (debounce_ok(ev.now_ms)) begin
          res.accepted = 1'b1;
          click_limit = last_click + click_gap_ms;
          if (ev.now_ms > click_limit) begin
            click_flag = 1'b1;
            upd_flag   = 1'b1;
            last_click = ev.now_ms;
            n_clicks++;
          end
        end else begin
          n_rejected++;
        end
      end
      rkdt_pkg::OP_ACK: begin
        upd_flag   = 1'b0;
        click_flag = 1'b0;
      end
      rkdt_pkg::OP_LOAD: begin
        knob_pos = ev.new_position;
        upd_flag = 1'b1;
      end
      default: ;
    endcase
    res.position = knob_pos;
    res.updated  = upd_flag;
    res.clicked  = click_flag;
    expected_results.push_back(res);
    n_events++;
  endfunction

  function void compare_field(string fld, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, fld, want, got);
      n_errors++;
    end
  endfunction

  function void check_result(rkdt_pkg::out_item_t got);
    rkdt_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no event pending, expected none actual %h",
               $time, got);
      n_errors++;
      return;
    end
    want = expected_results.pop_front();
    n_checked++;
    compare_field("position", want.position, got.position);
    compare_field("updated", 16'(want.updated), 16'(got.updated));
    compare_field("clicked", 16'(want.clicked), 16'(got.clicked));
    compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
  endfunction
endclass

module tb;

  // cycles after the last result before the block counts as idle
  localparam int DRAIN_CYCLES = 4;
  // longest receiver hold-off, well above the two-deep pipeline
  localparam int LONG_HOLD    = 80;
  // cycles without any transaction before the run is abandoned
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 200;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  rkdt_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  rkdt_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic [rkdt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rkdt_pkg::CFG_W-1:0]     cfg_wdata;

  knob_scoreboard sb = new();

  // sender burst bookkeeping and the request for a long receiver hold-off
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;
  int unsigned n_settings = 1;

  rotary_knob_debounce_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every result transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: segments of random stall behaviour, plus one long hold-off
  // whenever the stimulus asks for it
  initial begin : receiver
    int unsigned mode;
    int unsigned seg_left;
    int unsigned cyc;
    mode      = 0;
    seg_left  = 0;
    cyc       = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0: out_ready <= 1'b1;                          // no stalls at all
          1: out_ready <= 1'($urandom_range(0, 1));      // coin toss
          2: out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: out_ready <= ((cyc % 8) < 5);         // fixed on/off rhythm
        endcase
      end
    end
  end

  // watchdog: gives up when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("rotary_knob_debounce_tracker: mismatch");
    $finish;
  end

  function automatic rkdt_pkg::in_item_t mk_event(rkdt_pkg::op_t op,
                                                  logic [rkdt_pkg::NOW_W-1:0] now,
                                                  logic c, logic d,
                                                  logic [rkdt_pkg::POS_W-1:0] np);
    rkdt_pkg::in_item_t ev;
    ev.opcode       = op;
    ev.now_ms       = now;
    ev.clk_level    = c;
    ev.dt_level     = d;
    ev.new_position = np;
    return ev;
  endfunction

  // random event, with time stamps mostly placed around the debounce and
  // click limits seen from the current state, so both outcomes are common
  function automatic rkdt_pkg::in_item_t make_event();
    rkdt_pkg::in_item_t ev;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) ev.opcode = rkdt_pkg::OP_ROTATE;
    else if (pick < 72) ev.opcode = rkdt_pkg::OP_PRESS;
    else if (pick < 86) ev.opcode = rkdt_pkg::OP_ACK;
    else ev.opcode = rkdt_pkg::OP_LOAD;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // right at the debounce limit, one below to two above
      ev.now_ms = 32'(sb.last_evt + sb.debounce_ms + $urandom_range(0, 3) - 1);
    end else if (pick < 55 && ev.opcode == rkdt_pkg::OP_PRESS) begin
      ev.now_ms = 32'(sb.last_click + sb.click_gap_ms + $urandom_range(0, 3) - 1);
    end else if (pick < 85) begin
      ev.now_ms = 32'(sb.last_evt + $urandom_range(0, 2 * sb.debounce_ms + 8));
    end else if (pick < 93) begin
      ev.now_ms = 32'(sb.last_evt + $urandom_range(0, 200000));
    end else begin
      // anywhere in the stamp range, wrap included
      ev.now_ms = $urandom();
    end
    ev.clk_level    = 1'($urandom_range(0, 1));
    ev.dt_level     = 1'($urandom_range(0, 1));
    ev.new_position = 16'($urandom());
    return ev;
  endfunction

  // offers one event and returns at the edge that accepts it, with valid
  // still high; the caller either offers the next one or lowers valid
  // in the same step
  task automatic offer(input rkdt_pkg::in_item_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_data  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(ev);
  endtask

  // wait for every predicted result, then for the pipeline to empty
  task automatic wait_drain();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [rkdt_pkg::CFG_W-1:0] deb,
                              input logic [rkdt_pkg::CFG_W-1:0] sep);
    cfg_we    <= 1'b1;
    cfg_index <= rkdt_pkg::REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    sb.set_reg(rkdt_pkg::REG_DEBOUNCE, deb);
    cfg_index <= rkdt_pkg::REG_CLICK_SEP;
    cfg_wdata <= sep;
    @(posedge clk);
    sb.set_reg(rkdt_pkg::REG_CLICK_SEP, sep);
    cfg_we <= 1'b0;
  endtask

  // one register setting: random events, optionally a long receiver
  // hold-off at the start and a full sender pause half way
  task automatic run_phase(input logic [rkdt_pkg::CFG_W-1:0] deb,
                           input logic [rkdt_pkg::CFG_W-1:0] sep,
                           input bit hold, input bit pause);
    rkdt_pkg::in_item_t ev;
    write_config(deb, sep);
    n_settings++;
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (pause && i == PHASE_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait_drain();
      end
      ev = make_event();
      offer(ev);
    end
    in_valid <= 1'b0;
    wait_drain();
  endtask

  initial begin : stimulus
    // all inputs known from time zero, reset held low at the start
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = rkdt_pkg::REG_DEBOUNCE;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset delays of 50 ms and 1000 ms
    // not past the limit
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd0, 1'b0, 1'b0, 16'h7fff));
    // equal levels, step up
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd51, 1'b0, 1'b0, 16'h0000));
    // exactly on the limit
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd101, 1'b1, 1'b1, 16'h0000));
    // step down
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd102, 1'b1, 1'b0, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd200, 1'b0, 1'b1, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd300, 1'b1, 1'b1, 16'hffff));
    // debounced, click too soon
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'd400, 1'b1, 1'b0, 16'h0000));
    // inside quiet time
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'd420, 1'b0, 1'b0, 16'h0000));
    // real click
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'd1500, 1'b0, 1'b1, 16'h0000));
    // levels and value ignored
    offer(mk_event(rkdt_pkg::OP_ACK, 32'd1500, 1'b1, 1'b1, 16'h1234));
    // click too soon again
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'd1600, 1'b0, 1'b0, 16'h0000));
    // most negative position
    offer(mk_event(rkdt_pkg::OP_LOAD, 32'd1600, 1'b1, 1'b0, 16'h8000));
    // wraps to most positive
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd1700, 1'b0, 1'b1, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_LOAD, 32'd0, 1'b0, 1'b1, 16'h7fff));
    // wraps to most negative
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd1800, 1'b1, 1'b1, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_ACK, 32'd0, 1'b0, 1'b0, 16'h0000));
    // top of the stamp
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'hffff_ffff, 1'b0, 1'b0, 16'h0000));
    // wrapped limit, too early
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd20, 1'b1, 1'b0, 16'h0000));
    // early accept after wrap
    offer(mk_event(rkdt_pkg::OP_ROTATE, 32'd50, 1'b1, 1'b0, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'hffff_fff0, 1'b1, 1'b1, 16'h0000));
    // wrapped debounce limit
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'd30, 1'b0, 1'b0, 16'h0000));
    // wrapped click limit
    offer(mk_event(rkdt_pkg::OP_PRESS, 32'd40, 1'b0, 1'b0, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_LOAD, 32'hffff_ffff, 1'b1, 1'b1, 16'h0000));
    offer(mk_event(rkdt_pkg::OP_ACK, 32'hffff_ffff, 1'b1, 1'b0, 16'hffff));
    in_valid <= 1'b0;
    wait_drain();

    // random part over several settings, extremes first
    run_phase(16'd0, 16'd0, 1'b1, 1'b0);
    run_phase(16'hffff, 16'hffff, 1'b0, 1'b1);
    run_phase(16'd3, 16'd20, 1'b1, 1'b0);
    run_phase(16'hffff, 16'd0, 1'b0, 1'b0);
    run_phase(16'd0, 16'hffff, 1'b0, 1'b1);
    run_phase(16'($urandom()), 16'($urandom()), 1'b0, 1'b0);
    run_phase(rkdt_pkg::DEBOUNCE_RESET, rkdt_pkg::CLICK_SEP_RESET, 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    $display("covered %0d events under %0d register settings, %0d results checked",
             sb.n_events, n_settings, sb.n_checked);
    $display("  %0d rotate steps, %0d clicks, %0d debounce rejections",
             sb.n_steps, sb.n_clicks, sb.n_rejected);
    if (sb.n_errors == 0 && sb.expected_results.size() == 0) begin
      $display("rotary_knob_debounce_tracker: match");
    end else begin
      $display("rotary_knob_debounce_tracker: mismatch");
    end
    $finish;
  end

endmodule
